FILE: src/cia_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cia_pkg
// shared codes, widths and the item record that walks the divider cell row
// ----------------------------------------------------------------------------
package cia_pkg;

  localparam int unsigned DataW   = 64;
  localparam int unsigned ModeW   = 3;
  localparam int unsigned StatW   = 2;
  localparam int unsigned NumCells = DataW;

  localparam logic [ModeW-1:0] ModeUadd = 3'd0;
  localparam logic [ModeW-1:0] ModeUsub = 3'd1;
  localparam logic [ModeW-1:0] ModeUmul = 3'd2;
  localparam logic [ModeW-1:0] ModeUdiv = 3'd3;
  localparam logic [ModeW-1:0] ModeSadd = 3'd4;
  localparam logic [ModeW-1:0] ModeSsub = 3'd5;
  localparam logic [ModeW-1:0] ModeSmul = 3'd6;

  localparam logic [StatW-1:0] StatOk   = 2'd0;
  localparam logic [StatW-1:0] StatOvf  = 2'd1;
  localparam logic [StatW-1:0] StatDivz = 2'd2;

  localparam logic [DataW-1:0] SignBit = {1'b1, {(DataW-1){1'b0}}};

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [DataW-1:0] divisor;
    logic [DataW-1:0] rem;
    logic [DataW-1:0] quo;
    logic [DataW-1:0] side_res;
    logic [StatW-1:0] side_st;
  } cell_t;

endpackage
`default_nettype wire

FILE: src/cia_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cia_in_if / cia_out_if
// valid/ready channels for operation items and result items
// ----------------------------------------------------------------------------
interface cia_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [63:0] operand_a;
  logic [63:0] operand_b;
  modport source (output valid, mode, operand_a, operand_b, input ready);
  modport sink (input valid, mode, operand_a, operand_b, output ready);
  modport monitor (input valid, ready, mode, operand_a, operand_b);
endinterface

interface cia_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_value;
  logic [1:0]  status;
  modport source (output valid, result_value, status, input ready);
  modport sink (input valid, result_value, status, output ready);
  modport monitor (input valid, ready, result_value, status);
endinterface
`default_nettype wire

FILE: src/cia_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cia_front
// four-stage front end: add/sub checks, split 64x64 multiply, overflow checks
// ----------------------------------------------------------------------------
module cia_front import cia_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire logic [ModeW-1:0] mode_i,
  input  wire logic [DataW-1:0] a_i,
  input  wire logic [DataW-1:0] b_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output cell_t                 data_o
);

  logic v0_q, v1_q, v2_q, v3_q;
  logic adv0, adv1, adv2, adv3;

  // stage 0: operands and multiplier magnitudes
  logic [ModeW-1:0] m0_q;
  logic [DataW-1:0] a0_q, b0_q, xa0_q, xb0_q;
  logic             neg0_q;
  logic [DataW-1:0] ma, mb;

  // stage 1: partial products and add/sub results
  logic [ModeW-1:0] m1_q;
  logic [DataW-1:0] a1_q, b1_q;
  logic             neg1_q;
  logic [DataW-1:0] ll1_q, lh1_q, hl1_q, hh1_q;
  logic [DataW-1:0] res1_d, res1_q;
  logic [StatW-1:0] st1_d, st1_q;
  logic [DataW-1:0] dif;

  // stage 2: assembled product
  logic [ModeW-1:0] m2_q;
  logic [DataW-1:0] a2_q, b2_q;
  logic             neg2_q;
  logic [DataW-1:0] res2_q;
  logic [StatW-1:0] st2_q;
  logic [DataW-1:0] lo2_q;
  logic             hinz2_q;
  logic [33:0]      mid;
  logic [DataW-1:0] hi;

  // stage 3: multiply overflow and final side result
  cell_t            c3_d, c3_q;

  assign adv3    = !v3_q || ready_i;
  assign adv2    = !v2_q || adv3;
  assign adv1    = !v1_q || adv2;
  assign adv0    = !v0_q || adv1;
  assign ready_o = adv0;
  assign valid_o = v3_q;
  assign data_o  = c3_q;

  assign ma = a_i[DataW-1] ? (~a_i + 1'b1) : a_i;
  assign mb = b_i[DataW-1] ? (~b_i + 1'b1) : b_i;

  assign dif = a0_q - b0_q;

  always_comb begin
    logic [DataW:0] s;
    s      = {1'b0, a0_q} + {1'b0, b0_q};
    res1_d = '0;
    st1_d  = StatOk;
    case (m0_q)
      ModeUadd: begin
        if (s[DataW]) st1_d = StatOvf;
        else res1_d = s[DataW-1:0];
      end
      ModeUsub: begin
        if (b0_q > a0_q) st1_d = StatOvf;
        else res1_d = dif;
      end
      ModeUdiv: begin
        if (b0_q == '0) st1_d = StatDivz;
      end
      ModeSadd: begin
        if (((a0_q ^ s[DataW-1:0]) & (b0_q ^ s[DataW-1:0]) & SignBit) != '0) st1_d = StatOvf;
        else res1_d = s[DataW-1:0];
      end
      ModeSsub: begin
        if (((a0_q ^ b0_q) & (a0_q ^ dif) & SignBit) != '0) st1_d = StatOvf;
        else res1_d = dif;
      end
      default: begin
        res1_d = '0;
        st1_d  = StatOk;
      end
    endcase
  end

  assign mid = {2'b0, ll1_q[63:32]} + {2'b0, lh1_q[31:0]} + {2'b0, hl1_q[31:0]};
  assign hi  = hh1_q + {32'b0, lh1_q[63:32]} + {32'b0, hl1_q[63:32]} + {62'b0, mid[33:32]};

  always_comb begin
    c3_d          = '0;
    c3_d.mode     = m2_q;
    c3_d.divisor  = b2_q;
    c3_d.rem      = '0;
    c3_d.quo      = a2_q;
    c3_d.side_res = res2_q;
    c3_d.side_st  = st2_q;
    case (m2_q)
      ModeUmul: begin
        if (hinz2_q) begin
          c3_d.side_st  = StatOvf;
          c3_d.side_res = '0;
        end else begin
          c3_d.side_st  = StatOk;
          c3_d.side_res = lo2_q;
        end
      end
      ModeSmul: begin
        c3_d.side_st  = StatOk;
        c3_d.side_res = '0;
        if (hinz2_q) c3_d.side_st = StatOvf;
        else if (neg2_q) begin
          if (lo2_q > SignBit) c3_d.side_st = StatOvf;
          else c3_d.side_res = ~lo2_q + 1'b1;
        end else begin
          if (lo2_q >= SignBit) c3_d.side_st = StatOvf;
          else c3_d.side_res = lo2_q;
        end
      end
      default: begin
        c3_d.side_res = res2_q;
        c3_d.side_st  = st2_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv0) v0_q <= valid_i;
      if (adv1) v1_q <= v0_q;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv0 && valid_i) begin
      m0_q   <= mode_i;
      a0_q   <= a_i;
      b0_q   <= b_i;
      xa0_q  <= (mode_i == ModeSmul) ? ma : a_i;
      xb0_q  <= (mode_i == ModeSmul) ? mb : b_i;
      neg0_q <= a_i[DataW-1] ^ b_i[DataW-1];
    end
    if (adv1 && v0_q) begin
      m1_q   <= m0_q;
      a1_q   <= a0_q;
      b1_q   <= b0_q;
      neg1_q <= neg0_q;
      ll1_q  <= xa0_q[31:0] * xb0_q[31:0];
      lh1_q  <= xa0_q[31:0] * xb0_q[63:32];
      hl1_q  <= xa0_q[63:32] * xb0_q[31:0];
      hh1_q  <= xa0_q[63:32] * xb0_q[63:32];
      res1_q <= res1_d;
      st1_q  <= st1_d;
    end
    if (adv2 && v1_q) begin
      m2_q    <= m1_q;
      a2_q    <= a1_q;
      b2_q    <= b1_q;
      neg2_q  <= neg1_q;
      res2_q  <= res1_q;
      st2_q   <= st1_q;
      lo2_q   <= {mid[31:0], ll1_q[31:0]};
      hinz2_q <= (hi != '0);
    end
    if (adv3 && v2_q) begin
      c3_q <= c3_d;
    end
  end

endmodule
`default_nettype wire

FILE: src/cia_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cia_cell
// one restoring division step: one quotient bit per cell, item moves on
// ----------------------------------------------------------------------------
module cia_cell import cia_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  valid_i,
  output logic       ready_o,
  input  wire cell_t data_i,
  output logic       valid_o,
  input  wire logic  ready_i,
  output cell_t      data_o
);

  logic           v_q;
  logic           adv;
  cell_t          c_d, c_q;
  logic [DataW:0] trial;
  logic [DataW:0] diff;
  logic           ge;

  assign adv     = !v_q || ready_i;
  assign ready_o = adv;
  assign valid_o = v_q;
  assign data_o  = c_q;

  assign trial = {data_i.rem, data_i.quo[DataW-1]};
  assign diff  = trial - {1'b0, data_i.divisor};
  assign ge    = !diff[DataW];

  always_comb begin
    c_d     = data_i;
    c_d.rem = ge ? diff[DataW-1:0] : trial[DataW-1:0];
    c_d.quo = {data_i.quo[DataW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (adv) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && valid_i) c_q <= c_d;
  end

endmodule
`default_nettype wire

FILE: src/cia_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cia_back
// ceiling correction, result select and output register
// ----------------------------------------------------------------------------
module cia_back import cia_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  output logic                   ready_o,
  input  wire cell_t             data_i,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output logic [DataW-1:0]       res_o,
  output logic [StatW-1:0]       st_o
);

  logic             v_q, adv;
  logic [DataW-1:0] res_d, res_q;
  logic [StatW-1:0] st_q;

  assign adv     = !v_q || ready_i;
  assign ready_o = adv;
  assign valid_o = v_q;
  assign res_o   = res_q;
  assign st_o    = st_q;

  always_comb begin
    res_d = data_i.side_res;
    if (data_i.mode == ModeUdiv && data_i.side_st == StatOk) begin
      res_d = data_i.quo + {{(DataW-1){1'b0}}, (data_i.rem != '0)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (adv) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && valid_i) begin
      res_q <= res_d;
      st_q  <= data_i.side_st;
    end
  end

endmodule
`default_nettype wire

FILE: src/checked_integer_alu_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// checked_integer_alu_unit
// 64-bit integer alu with exact overflow and divide-by-zero status
// ----------------------------------------------------------------------------
// channel  dir  handshake     payload
// in_i     in   valid/ready   mode, operand_a, operand_b
// out_o    out  valid/ready   result_value, status
//
// one item per cycle while out_o is not stalled; 4 front stages, 64 division
// cells and the output register lie between in_i and out_o.
// reset clears all stage valid bits; no state survives an item.
// each stage holds its item while the next one is full and stalled, so
// empty stages keep filling while a result waits at the output.
// ----------------------------------------------------------------------------
module checked_integer_alu_unit import cia_pkg::*; (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  cia_in_if.sink     in_i,
  cia_out_if.source  out_o
);

  logic              f_valid, f_ready;
  cell_t             f_data;
  logic [NumCells:0] cv;
  logic [NumCells:0] cr;
  cell_t             cd [NumCells+1];

  cia_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .mode_i  (in_i.mode),
    .a_i     (in_i.operand_a),
    .b_i     (in_i.operand_b),
    .valid_o (f_valid),
    .ready_i (f_ready),
    .data_o  (f_data)
  );

  assign cv[0]   = f_valid;
  assign cd[0]   = f_data;
  assign f_ready = cr[0];

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    cia_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cv[i]),
      .ready_o (cr[i]),
      .data_i  (cd[i]),
      .valid_o (cv[i+1]),
      .ready_i (cr[i+1]),
      .data_o  (cd[i+1])
    );
  end

  cia_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cv[NumCells]),
    .ready_o (cr[NumCells]),
    .data_i  (cd[NumCells]),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .res_o   (out_o.result_value),
    .st_o    (out_o.status)
  );

endmodule
`default_nettype wire

FILE: src/cia_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cia_checker
// port-level checks on result items
// ----------------------------------------------------------------------------
module cia_checker import cia_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             valid_i,
  input wire logic             ready_i,
  input wire logic [DataW-1:0] result_value_i,
  input wire logic [StatW-1:0] status_i
);

  a_stat_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> (status_i == StatOk || status_i == StatOvf || status_i == StatDivz))
    else $error("bad status code");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && status_i != StatOk) |-> (result_value_i == '0))
    else $error("nonzero result with error status");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !ready_i) |=>
      (valid_i && $stable(result_value_i) && $stable(status_i)))
    else $error("stalled item changed");

endmodule

bind checked_integer_alu_unit cia_checker u_cia_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .valid_i        (out_o.valid),
  .ready_i        (out_o.ready),
  .result_value_i (out_o.result_value),
  .status_i       (out_o.status)
);
`default_nettype wire
